@@ rtl/core/ftema_pkg.sv @@
`default_nettype none

package ftema_pkg;

  localparam int FRAC_BITS = 16;

  localparam int SMP_W   = 32;
  localparam int AVG_W   = 31;
  localparam int FPS_W   = 16;
  localparam int ALPHA_W = 16;
  localparam int RAMP_W  = 8;
  localparam int IDX_W   = 2;
  localparam int CFG_W   = 16;

  localparam logic [IDX_W-1:0] REG_ALPHA_FAST   = 2'd0;
  localparam logic [IDX_W-1:0] REG_ALPHA_STABLE = 2'd1;
  localparam logic [IDX_W-1:0] REG_RAMP_FRAMES  = 2'd2;
  localparam logic [IDX_W-1:0] REG_FPS_LIMIT    = 2'd3;

  localparam logic [ALPHA_W-1:0] ALPHA_FAST_RST   = 16'd29491;
  localparam logic [ALPHA_W-1:0] ALPHA_STABLE_RST = 16'd13107;
  localparam logic [RAMP_W-1:0]  RAMP_FRAMES_RST  = 8'd20;
  localparam logic [FPS_W-1:0]   FPS_LIMIT_RST    = 16'd9999;

  localparam logic [RAMP_W-1:0]  FC_MAX = {RAMP_W{1'b1}};

  // rate numerator: 2000 * 2^FRAC_BITS + avg, divided by 2 * avg
  localparam longint unsigned FPS_NUM = 64'd2000 << FRAC_BITS;
  localparam longint unsigned AVG_MAX = (64'd1 << AVG_W) - 64'd1;
  localparam int NUM_W = $clog2(FPS_NUM + AVG_MAX + 64'd1);
  localparam int DEN_W = AVG_W + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam int D_W    = AVG_W + 2;
  localparam int PROD_W = ALPHA_W + 1 + D_W;
  localparam int MIX_W  = AVG_W + ALPHA_W + 4;
  localparam longint unsigned ALPHA_HALF = 64'd1 << (ALPHA_W - 1);

  typedef struct packed {
    logic                    command;
    logic signed [SMP_W-1:0] sample_ms;
    logic                    sample_invalid;
  } in_item_t;

  typedef struct packed {
    logic [AVG_W-1:0] avg_ms;
    logic [FPS_W-1:0] fps;
  } out_item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha_fast;
    logic [ALPHA_W-1:0] alpha_stable;
    logic [RAMP_W-1:0]  ramp_frames;
    logic [FPS_W-1:0]   fps_limit;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic update;
    logic mul;
    logic mix;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/ftema_ctrl.sv @@
`default_nettype none

module ftema_ctrl
  import ftema_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_MIX  = 3'd3;
  localparam logic [2:0] S_DIVI = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ftema_dp.sv @@
`default_nettype none

module ftema_dp
  import ftema_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  in_item_t  in_data,
  input  cfg_t      cfg,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_item_t out_data
);

  logic                     cmd_r;
  logic                     inv_r;
  logic [AVG_W-1:0]         s_r;
  logic [AVG_W-1:0]         avg_r, avg_nxt;
  logic                     started_r, started_nxt;
  logic [RAMP_W-1:0]        fc_r, fc_nxt;
  logic                     blend_r, blend_nxt;
  logic [ALPHA_W-1:0]       a_r, a_nxt;
  logic signed [D_W-1:0]    d_r, d_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [NUM_W-1:0]         num_r;
  logic [DEN_W-1:0]         den_r;
  logic [DEN_W-1:0]         rem_r;
  logic [CNT_W-1:0]         cnt_r;
  out_item_t                out_r;

  logic [DEN_W-1:0]         lo, hi, s_ext, s_c;
  logic [MIX_W-1:0]         mix;
  logic [DEN_W:0]           trial;
  logic                     fit;
  logic [NUM_W-1:0]         lim;
  logic [FPS_W-1:0]         fps;

  assign lo    = {1'b0, 1'b0, avg_r[AVG_W-1:1]};
  assign hi    = {avg_r, 1'b0};
  assign s_ext = {1'b0, s_r};

  always_comb begin
    s_c = (s_ext < lo) ? lo : s_ext;
    if (s_c > hi) begin
      s_c = hi;
    end
  end

  always_comb begin
    avg_nxt     = avg_r;
    started_nxt = started_r;
    fc_nxt      = fc_r;
    blend_nxt   = blend_r;
    a_nxt       = a_r;
    d_nxt       = d_r;
    if (cmd.update) begin
      blend_nxt = 1'b0;
      if (cmd_r) begin
        avg_nxt     = '0;
        started_nxt = 1'b0;
        fc_nxt      = '0;
      end else if (!inv_r) begin
        if (!started_r) begin
          avg_nxt     = s_r;
          started_nxt = 1'b1;
          fc_nxt      = RAMP_W'(1);
        end else begin
          a_nxt = (fc_r < cfg.ramp_frames) ? cfg.alpha_fast : cfg.alpha_stable;
          if (fc_r != FC_MAX) begin
            fc_nxt = fc_r + RAMP_W'(1);
          end
          if (avg_r == '0) begin
            avg_nxt = s_r;
          end else begin
            blend_nxt = 1'b1;
            d_nxt     = $signed({1'b0, s_c}) - $signed({2'b00, avg_r});
          end
        end
      end
    end
    if (cmd.mix && blend_r) begin
      avg_nxt = mix[ALPHA_W +: AVG_W];
    end
  end

  assign prod_nxt = $signed({1'b0, a_r}) * d_r;

  // avg * 2^16 + a * (s - avg) + half
  assign mix = {{(MIX_W-AVG_W-ALPHA_W){1'b0}}, avg_r, {ALPHA_W{1'b0}}}
             + {{(MIX_W-PROD_W){prod_r[PROD_W-1]}}, prod_r}
             + MIX_W'(ALPHA_HALF);

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fit   = (trial >= {1'b0, den_r});

  assign sts.div_last = (cnt_r == CNT_W'(1));

  assign lim = NUM_W'(cfg.fps_limit);
  always_comb begin
    if (avg_r == '0) begin
      fps = '0;
    end else if (num_r > lim) begin
      fps = cfg.fps_limit;
    end else begin
      fps = num_r[FPS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r     <= '0;
      started_r <= 1'b0;
      fc_r      <= '0;
      blend_r   <= 1'b0;
    end else begin
      avg_r     <= avg_nxt;
      started_r <= started_nxt;
      fc_r      <= fc_nxt;
      blend_r   <= blend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    d_r <= d_nxt;
    if (cmd.take) begin
      cmd_r <= in_data.command;
      inv_r <= in_data.sample_invalid;
      s_r   <= in_data.sample_ms[SMP_W-1] ? '0 : in_data.sample_ms[AVG_W-1:0];
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.div_init) begin
      num_r <= NUM_W'(FPS_NUM) + NUM_W'(avg_r);
      den_r <= {avg_r, 1'b0};
      rem_r <= '0;
      cnt_r <= CNT_W'(NUM_W);
    end else if (cmd.div_step) begin
      rem_r <= fit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      num_r <= {num_r[NUM_W-2:0], fit};
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_r.avg_ms <= avg_r;
      out_r.fps    <= fps;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

@@ rtl/core/frame_time_ema_fps_meter.sv @@
`default_nettype none

// Frame-time EMA meter. Each transfer on the input channel (a Q16.16 ms sample,
// or a clear command) yields one transfer on the output channel carrying the
// smoothed frame time and the rounded, capped frame rate. An item passes through
// the accepting step, then update and clamp, multiply, blend and divider setup,
// then a restoring divider that retires one quotient bit per cycle for the rate,
// then the load of the output register once that register is free.
// A finished result waits in that register, so the next item may be taken
// while it is still unread. Configuration writes take effect at once and are
// meant for an idle block.
module frame_time_ema_fps_meter
  import ftema_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output out_item_t        out_data,
  input  wire              cfg_we,
  input  wire  [IDX_W-1:0] cfg_index,
  input  wire  [CFG_W-1:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;
  sts_t sts;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ALPHA_FAST:   cfg_nxt.alpha_fast   = cfg_wdata[ALPHA_W-1:0];
        REG_ALPHA_STABLE: cfg_nxt.alpha_stable = cfg_wdata[ALPHA_W-1:0];
        REG_RAMP_FRAMES:  cfg_nxt.ramp_frames  = cfg_wdata[RAMP_W-1:0];
        REG_FPS_LIMIT:    cfg_nxt.fps_limit    = cfg_wdata[FPS_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha_fast   <= ALPHA_FAST_RST;
      cfg_r.alpha_stable <= ALPHA_STABLE_RST;
      cfg_r.ramp_frames  <= RAMP_FRAMES_RST;
      cfg_r.fps_limit    <= FPS_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ftema_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ftema_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

@@ verif/frame_time_ema_fps_meter_tb.sv @@
`timescale 1ns / 1ps

module frame_time_ema_fps_meter_tb;
  import ftema_pkg::*;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;
  localparam int   N_PHASES   = 8;
  localparam int   PHASE_LEN  = 200;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  frame_time_ema_fps_meter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // meter state and register copies
  logic [AVG_W-1:0]   ema_avg     = '0;
  logic               ema_started = 1'b0;
  logic [RAMP_W-1:0]  ema_frames  = '0;
  logic [ALPHA_W-1:0] w_fast      = ALPHA_FAST_RST;
  logic [ALPHA_W-1:0] w_stable    = ALPHA_STABLE_RST;
  logic [RAMP_W-1:0]  ramp_len    = RAMP_FRAMES_RST;
  logic [FPS_W-1:0]   rate_cap    = FPS_LIMIT_RST;

  in_item_t  frames_to_send[$];
  out_item_t expected_readings[$];
  out_item_t want;

  int          mismatch_cnt = 0;
  int          readings_seen = 0;
  int          send_gap = 0;
  int          ready_gap = 0;
  int          hold_left = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  longint unsigned frame_base = 64'h10AAB;

  function automatic out_item_t meter_step(in_item_t it);
    out_item_t       r;
    longint unsigned s, avg, wt, mix, q;
    if (it.command == CMD_CLEAR) begin
      ema_avg     = '0;
      ema_started = 1'b0;
      ema_frames  = '0;
    end else if (!it.sample_invalid) begin
      s = it.sample_ms[SMP_W-1] ? 64'd0 : {32'd0, it.sample_ms};
      if (!ema_started) begin
        ema_avg     = s[AVG_W-1:0];
        ema_frames  = RAMP_W'(1);
        ema_started = 1'b1;
      end else begin
        wt  = (ema_frames < ramp_len) ? w_fast : w_stable;
        avg = ema_avg;
        if (avg == 0) begin
          ema_avg = s[AVG_W-1:0];
        end else begin
          if (s < (avg >> 1)) s = avg >> 1;
          if (s > 2 * avg) s = 2 * avg;
          mix = wt * s + ((64'd1 << ALPHA_W) - wt) * avg + ALPHA_HALF;
          mix = mix >> ALPHA_W;
          ema_avg = mix[AVG_W-1:0];
        end
        if (ema_frames != FC_MAX) ema_frames++;
      end
    end
    avg = ema_avg;
    q = 0;
    if (avg != 0) begin
      q = (FPS_NUM + avg) / (2 * avg);
      if (q > rate_cap) q = rate_cap;
    end
    r.avg_ms = ema_avg;
    r.fps    = q[FPS_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(40, 120);
  endfunction

  function automatic in_item_t next_frame(int unsigned clear_pm);
    in_item_t        it;
    longint unsigned v;
    int unsigned     r;
    it = '0;
    if ($urandom_range(0, 999) < clear_pm) begin
      it.command        = CMD_CLEAR;
      it.sample_ms      = $urandom;
      it.sample_invalid = $urandom_range(0, 1);
      return it;
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      v = frame_base - (frame_base >> 4)
        + 64'($urandom_range(0, int'(frame_base >> 3)));
    end else if (r < 78) begin
      v = frame_base * 64'($urandom_range(3, 8));
      if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
    end else if (r < 84) begin
      v = frame_base >> $urandom_range(2, 5);
    end else if (r < 88) begin
      v = 64'($urandom);
    end else if (r < 92) begin
      v = 64'h8000_0000 | 64'($urandom);
    end else if (r < 94) begin
      v = 0;
    end else if (r < 96) begin
      v = 64'($urandom_range(0, 2000));
    end else begin
      case ($urandom_range(0, 9))
        0:       frame_base = 64'($urandom_range(1, 32'hFFFF));
        1:       frame_base = 64'($urandom_range(32'h1_0000, 32'h4000_0000));
        default: frame_base = 64'($urandom_range(32'h1_0000, 32'h64_0000));
      endcase
      v = frame_base;
    end
    it.command        = CMD_SAMPLE;
    it.sample_ms      = v[31:0];
    it.sample_invalid = ($urandom_range(0, 99) < 4);
    return it;
  endfunction

  task automatic send(logic cmd, logic [31:0] v, logic inv);
    in_item_t it;
    it.command        = cmd;
    it.sample_ms      = v;
    it.sample_invalid = inv;
    frames_to_send.push_back(it);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (frames_to_send.size() != 0 || in_valid || expected_readings.size() != 0);
  endtask

  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ALPHA_FAST:   w_fast   = val[ALPHA_W-1:0];
      REG_ALPHA_STABLE: w_stable = val[ALPHA_W-1:0];
      REG_RAMP_FRAMES:  ramp_len = val[RAMP_W-1:0];
      REG_FPS_LIMIT:    rate_cap = val[FPS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_set(logic [CFG_W-1:0] af, logic [CFG_W-1:0] as,
                         logic [CFG_W-1:0] rf, logic [CFG_W-1:0] fl);
    cfg_write(REG_ALPHA_FAST, af);
    cfg_write(REG_ALPHA_STABLE, as);
    cfg_write(REG_RAMP_FRAMES, rf);
    cfg_write(REG_FPS_LIMIT, fl);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender
  always @(posedge clk) begin
    if (in_valid && in_ready) expected_readings.push_back(meter_step(in_data));
    if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (rst_n && frames_to_send.size() != 0) begin
        in_data  <= frames_to_send.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      readings_seen++;
      if (expected_readings.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected reading: avg_ms=%0d fps=%0d", out_data.avg_ms, out_data.fps);
      end else begin
        want = expected_readings.pop_front();
        if (out_data.avg_ms !== want.avg_ms || out_data.fps !== want.fps) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("reading %0d: avg_ms exp %0d got %0d, fps exp %0d got %0d",
                     readings_seen, want.avg_ms, out_data.avg_ms, want.fps, out_data.fps);
        end
      end
      // long hold-off so the block backs up into its input
      if (readings_seen == 300) hold_left = 800;
      ready_gap = pick_gap(out_calm);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    int unsigned clear_pm[N_PHASES] = '{5, 0, 20, 0, 0, 30, 10, 60};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send(CMD_SAMPLE, 32'h0001_0AAB, 1'b1);  // ignored before any average
    send(CMD_CLEAR,  32'hFFFF_FFFF, 1'b1);
    send(CMD_SAMPLE, 32'h0010_AAAB, 1'b0);  // first sample loads
    send(CMD_SAMPLE, 32'h0000_0000, 1'b0);  // clamp to half
    send(CMD_SAMPLE, 32'h7FFF_FFFF, 1'b0);  // clamp to twice
    send(CMD_SAMPLE, 32'h8000_0000, 1'b0);  // negative -> 0
    send(CMD_SAMPLE, 32'hFFFF_FFFF, 1'b0);
    send(CMD_SAMPLE, 32'h0021_0000, 1'b1);  // invalid, state held
    send(CMD_SAMPLE, 32'h0011_0000, 1'b0);
    send(CMD_CLEAR,  32'h1234_5678, 1'b0);
    send(CMD_SAMPLE, 32'h8765_4321, 1'b0);  // first sample negative -> zero average
    send(CMD_SAMPLE, 32'h0000_0001, 1'b0);  // zero average replaced, rate capped
    send(CMD_SAMPLE, 32'h7FFF_FFFF, 1'b0);
    send(CMD_CLEAR,  32'h0000_0000, 1'b0);
    send(CMD_SAMPLE, 32'h7FFF_FFFF, 1'b0);  // rate rounds to zero
    send(CMD_SAMPLE, 32'h5555_5555, 1'b0);
    send(CMD_SAMPLE, 32'h2AAA_AAAA, 1'b0);
    send(CMD_CLEAR,  32'h0000_0000, 1'b1);
    send(CMD_SAMPLE, 32'h0001_0000, 1'b0);  // 1 ms
    send(CMD_SAMPLE, 32'h0000_8000, 1'b0);
    send(CMD_SAMPLE, 32'h0FA0_0000, 1'b0);
    send(CMD_SAMPLE, 32'hAAAA_AAAA, 1'b0);
    wait_idle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: cfg_set(ALPHA_FAST_RST, ALPHA_STABLE_RST, CFG_W'(RAMP_FRAMES_RST), FPS_LIMIT_RST);
        1: cfg_set(16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFFFF);
        2: cfg_set(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        3: cfg_set(16'hFFFF, 16'h0000, 16'h0001, 16'd100);
        default: cfg_set(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                         $urandom_range(0, 1) ? CFG_W'($urandom_range(1, 200))
                                              : CFG_W'($urandom));
      endcase
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      repeat (PHASE_LEN) frames_to_send.push_back(next_frame(clear_pm[ph]));
      wait_idle();
    end

    repeat (80) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
